/* rtl/ccmc_pkg.sv */
// ----------------------------------------------------------------------------
// ccmc_pkg
// Shared constants and the mnemonic table of the control-character codec.
// ----------------------------------------------------------------------------
package ccmc_pkg;

  localparam int unsigned MAX_TAG_BODY = 3;   // longest tag body that is kept
  localparam int unsigned NAME_SLOTS   = 3;   // stored body characters
  localparam int unsigned NUM_TAGS     = 34;
  localparam int unsigned DEL_INDEX    = 33;
  localparam int unsigned MAX_RESULTS  = 5;   // '[' + three chars + ']'

  localparam int unsigned TAG_IDX_W = $clog2(NUM_TAGS);
  localparam int unsigned CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int unsigned TCNT_W    = $clog2(MAX_TAG_BODY + 1);

  localparam logic [7:0] DEL_CODE = 8'h7F;
  localparam logic [7:0] SP_CODE  = 8'h20;
  localparam logic [7:0] OPEN_CH  = 8'h5B;    // '['
  localparam logic [7:0] CLOSE_CH = 8'h5D;    // ']'

  // register indexes on the APB port
  localparam logic REG_MODE = 1'b0;

  // mode codes
  localparam logic MODE_EXPAND   = 1'b0;
  localparam logic MODE_COLLAPSE = 1'b1;

  // first char in bits 23:16; two-letter names carry a zero third byte
  localparam logic [23:0] MNEM [NUM_TAGS] = '{
    "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
    {"BS", 8'h00}, {"HT", 8'h00}, {"NL", 8'h00}, {"VT", 8'h00},
    {"NP", 8'h00}, {"CR", 8'h00}, {"SO", 8'h00}, {"SI", 8'h00},
    "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB",
    "CAN", {"EM", 8'h00}, "SUB", "ESC",
    {"FS", 8'h00}, {"GS", 8'h00}, {"RS", 8'h00}, {"US", 8'h00},
    {"SP", 8'h00}, "DEL"
  };

endpackage

/* rtl/control_char_mnemonic_codec_top.sv */
// ----------------------------------------------------------------------------
// control_char_mnemonic_codec_top
// Byte-stream codec: expands control codes to bracketed mnemonics, or
// collapses such tags back to their codes, selected by the mode register.
// ----------------------------------------------------------------------------
// Flow: an accepted byte waits in the input register, is converted from there
//   and is loaded as a whole run into the result stage, whose head byte is presented on the master side.
// Pacing: a new run is loaded only when the result stage is empty or its last
//   byte leaves, a run being up to five bytes in expand mode; the master side
//   drains one byte per cycle while m_axis_tready is high.
// Reset (rst_ni low, asynchronous): mode = expand, no open tag, input and
//   result stages empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module control_char_mnemonic_codec_top
  import ccmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_packet
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // last_of_run
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic mode_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
  assign prdata = (paddr[2] == REG_MODE) ? {{31{1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EXPAND;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // Input register: one byte waits here until the result stage can take
  // its whole run.
  // --------------------------------------------------------------------------
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eop_q;

  // result stage: run of up to five bytes, head in slot 0
  logic [7:0]       res_q [MAX_RESULTS];
  logic [7:0]       res_d [MAX_RESULTS];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic advance;   // result stage empty, or its last byte leaves now
  logic load;      // input byte is converted and its run loaded
  logic pop;

  assign advance       = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_axis_tready);
  assign load          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = res_q[0];
  assign m_axis_tlast  = (cnt_q == CNT_W'(1));
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eop_q  <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Tag state (collapse mode)
  // --------------------------------------------------------------------------
  logic              tag_open_q, tag_open_d;
  logic [7:0]        tag_chars_q [NAME_SLOTS];
  logic [7:0]        tag_chars_d [NAME_SLOTS];
  logic [TCNT_W-1:0] tag_count_q, tag_count_d;
  logic              tag_overflow_q, tag_overflow_d;

  // --------------------------------------------------------------------------
  // Conversion of the byte in the input register
  // --------------------------------------------------------------------------
  logic [TAG_IDX_W-1:0] exp_idx;
  logic [23:0]          exp_name;
  logic                 exp_ctrl;
  logic                 hit;
  logic [7:0]           hit_code;
  logic [23:0]          ent;
  logic [TCNT_W-1:0]    ent_len;
  logic [7:0]           new_res [MAX_RESULTS];
  logic [CNT_W-1:0]     new_cnt;

  // known-tag search, one compare per table entry; the lowest matching index wins
  always_comb begin
    hit      = 1'b0;
    hit_code = '0;
    ent      = '0;
    ent_len  = '0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      ent     = MNEM[i];
      ent_len = (ent[7:0] != 8'h00) ? TCNT_W'(3) : TCNT_W'(2);
      if (!hit && (tag_count_q == ent_len) &&
          (tag_chars_q[0] == ent[23:16]) && (tag_chars_q[1] == ent[15:8]) &&
          ((ent_len == TCNT_W'(2)) || (tag_chars_q[2] == ent[7:0]))) begin
        hit      = 1'b1;
        hit_code = (i == DEL_INDEX) ? DEL_CODE : 8'(i);
      end
    end
  end

  assign exp_ctrl = (in_byte_q <= SP_CODE) || (in_byte_q == DEL_CODE);
  assign exp_idx  = (in_byte_q == DEL_CODE) ? TAG_IDX_W'(DEL_INDEX)
                                             : in_byte_q[TAG_IDX_W-1:0];
  assign exp_name = MNEM[exp_idx];

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      new_res[i] = '0;
    end
    new_cnt        = '0;
    tag_open_d     = tag_open_q;
    tag_chars_d    = tag_chars_q;
    tag_count_d    = tag_count_q;
    tag_overflow_d = tag_overflow_q;

    if (mode_q == MODE_EXPAND) begin
      if (exp_ctrl) begin
        new_res[0] = OPEN_CH;
        new_res[1] = exp_name[23:16];
        new_res[2] = exp_name[15:8];
        if (exp_name[7:0] != 8'h00) begin
          new_res[3] = exp_name[7:0];
          new_res[4] = CLOSE_CH;
          new_cnt    = CNT_W'(5);
        end else begin
          new_res[3] = CLOSE_CH;
          new_cnt    = CNT_W'(4);
        end
      end else begin
        new_res[0] = in_byte_q;
        new_cnt    = CNT_W'(1);
      end
    end else if (tag_open_q) begin
      if (in_byte_q == CLOSE_CH) begin
        // unknown, empty or over-long tags close silently
        if (hit && !tag_overflow_q) begin
          new_res[0] = hit_code;
          new_cnt    = CNT_W'(1);
        end
        tag_open_d     = 1'b0;
        tag_count_d    = '0;
        tag_overflow_d = 1'b0;
        for (int i = 0; i < NAME_SLOTS; i++) begin
          tag_chars_d[i] = '0;
        end
      end else if (tag_count_q >= TCNT_W'(MAX_TAG_BODY)) begin
        tag_overflow_d = 1'b1;
      end else begin
        tag_chars_d[tag_count_q] = in_byte_q;
        tag_count_d              = tag_count_q + TCNT_W'(1);
      end
    end else if (in_byte_q == OPEN_CH) begin
      tag_open_d     = 1'b1;
      tag_count_d    = '0;
      tag_overflow_d = 1'b0;
      for (int i = 0; i < NAME_SLOTS; i++) begin
        tag_chars_d[i] = '0;
      end
    end else begin
      new_res[0] = in_byte_q;
      new_cnt    = CNT_W'(1);
    end

    // end of buffer drops any open tag, in either mode
    if (in_eop_q) begin
      tag_open_d     = 1'b0;
      tag_count_d    = '0;
      tag_overflow_d = 1'b0;
      for (int i = 0; i < NAME_SLOTS; i++) begin
        tag_chars_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_open_q     <= 1'b0;
      tag_count_q    <= '0;
      tag_overflow_q <= 1'b0;
      for (int i = 0; i < NAME_SLOTS; i++) begin
        tag_chars_q[i] <= '0;
      end
    end else if (load) begin
      tag_open_q     <= tag_open_d;
      tag_count_q    <= tag_count_d;
      tag_overflow_q <= tag_overflow_d;
      tag_chars_q    <= tag_chars_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: loads a whole run, then shifts one byte out per transaction
  // --------------------------------------------------------------------------
  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      res_d[MAX_RESULTS-1] = '0;
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (load) begin
      res_d = new_res;
      cnt_d = new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result run longer than five bytes");

  a_closed_tag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tag_open_q |-> (tag_count_q == '0) && !tag_overflow_q)
    else $error("closed tag left body state behind");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_overflow_q |-> (tag_count_q == TCNT_W'(MAX_TAG_BODY)))
    else $error("tag overflow before body is full");

  a_eop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && in_eop_q |=> !tag_open_q)
    else $error("end of packet left a tag open");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (cnt_q == $past(new_cnt)))
    else $error("result run overwritten while draining");

endmodule

/* verif/tb_control_char_mnemonic_codec_top.sv */
// ----------------------------------------------------------------------------
// tb_control_char_mnemonic_codec_top
// Self-checking bench for the control-character codec. A short table of
// directed bytes is followed by random expand and collapse traffic. Every
// input transaction is run through a behavioural model of the codec, and
// each result transaction is compared with the oldest expected byte.
// ----------------------------------------------------------------------------
module tb_control_char_mnemonic_codec_top
  import ccmc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is abandoned
  localparam int SETTLE_CYCLES  = 8;     // margin after the last result before a write
  localparam int LONG_STALL     = 300;   // receiver hold-off, in cycles
  localparam int BURST_ITEMS    = 48;
  localparam int NAME_COUNT     = 34;
  localparam int DEL_SLOT       = 33;
  localparam logic [2:0] MODE_ADDR = 3'(4 * int'(REG_MODE));

  // one result byte as the master side carries it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_byte_t;

  // directed row: mode, input, and the result bytes typed in
  // (n_res < 0 leaves the row to the model)
  typedef struct packed {
    logic        mode;
    logic [7:0]  in_b;
    logic        eop;
    int          n_res;
    logic [39:0] res;
  } dir_row_t;

  localparam int PRED = -1;

  localparam dir_row_t DIR_ROWS [25] = '{
    '{MODE_EXPAND,   8'h00, 1'b0, 5,    "[NUL]"},
    '{MODE_EXPAND,   8'h20, 1'b0, 4,    "[SP]"},
    '{MODE_EXPAND,   8'h7F, 1'b0, 5,    "[DEL]"},
    '{MODE_EXPAND,   8'h1F, 1'b0, 4,    "[US]"},
    '{MODE_EXPAND,   8'hFF, 1'b1, 1,    40'hFF},
    '{MODE_EXPAND,   "[",   1'b0, 1,    "["},
    // collapse: lone close passes, then a full known tag
    '{MODE_COLLAPSE, "]",   1'b0, 1,    "]"},
    '{MODE_COLLAPSE, "[",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "N",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "U",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "L",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "]",   1'b0, 1,    40'h00},
    // open bracket inside a tag is body text, so the tag is unknown
    '{MODE_COLLAPSE, "[",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "[",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "N",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "]",   1'b0, PRED, 40'h0},
    // empty tag
    '{MODE_COLLAPSE, "[",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "]",   1'b0, 0,    40'h0},
    // body longer than three characters
    '{MODE_COLLAPSE, "[",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "E",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "S",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "C",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "X",   1'b0, 0,    40'h0},
    '{MODE_COLLAPSE, "]",   1'b0, PRED, 40'h0},
    // end of packet drops an unterminated tag; next byte is plain
    '{MODE_COLLAPSE, "[",   1'b1, 0,    40'h0}
  };

  string mnemonic_names [NAME_COUNT] = '{
    "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
    "BS",  "HT",  "NL",  "VT",  "NP",  "CR",  "SO",  "SI",
    "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB",
    "CAN", "EM",  "SUB", "ESC", "FS",  "GS",  "RS",  "US",
    "SP",  "DEL"
  };

  // --------------------------------------------------------------------------
  // DUT signals: every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;   // end_of_packet
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic        m_axis_tlast;           // last_of_run
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  control_char_mnemonic_codec_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  codec_byte_t pending_bytes [$];   // expected result bytes, oldest first
  int          mismatch_count = 0;
  int          tx_idle_pct    = 0;  // sender gap chance per cycle
  int          rx_idle_pct    = 0;  // receiver hold chance per cycle
  logic        long_stall_req = 1'b0;
  int          stall_left     = 0;
  bit          stall_taken    = 1'b0;
  int          quiet_cycles   = 0;

  // behavioural copy of the codec state
  logic        mode_q;
  logic        tag_open_q;
  logic [7:0]  tag_body_q [3];
  int          tag_len_q;
  logic        tag_ovf_q;

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Codec model
  // --------------------------------------------------------------------------
  function automatic void drop_tag();
    tag_open_q = 1'b0;
    tag_body_q = '{default: 8'h00};
    tag_len_q  = 0;
    tag_ovf_q  = 1'b0;
  endfunction

  // code of the tag held in the body, or -1 when it names nothing
  function automatic int tag_code();
    int  i;
    int  j;
    bit  hit;
    if (tag_ovf_q || tag_len_q == 0)
      return -1;
    for (i = 0; i < NAME_COUNT; i++) begin
      if (mnemonic_names[i].len() != tag_len_q)
        continue;
      hit = 1'b1;
      for (j = 0; j < tag_len_q; j++)
        if (8'(mnemonic_names[i].getc(j)) != tag_body_q[j])
          hit = 1'b0;
      if (hit)
        return (i == DEL_SLOT) ? int'(DEL_CODE) : i;
    end
    return -1;
  endfunction

  function automatic void codec_convert(input logic [7:0] b, input logic eop,
                                        output logic [7:0] res [5], output int n);
    int    code;
    int    j;
    string nm;
    n   = 0;
    res = '{default: 8'h00};
    if (mode_q == MODE_EXPAND) begin
      if (b <= 8'h20 || b == DEL_CODE) begin
        nm = mnemonic_names[(b == DEL_CODE) ? DEL_SLOT : int'(b)];
        res[0] = OPEN_CH;
        for (j = 0; j < nm.len(); j++)
          res[j + 1] = 8'(nm.getc(j));
        res[nm.len() + 1] = CLOSE_CH;
        n = nm.len() + 2;
      end else begin
        res[0] = b;
        n = 1;
      end
    end else if (tag_open_q) begin
      if (b == CLOSE_CH) begin
        code = tag_code();
        if (code >= 0) begin
          res[0] = 8'(code);
          n = 1;
        end
        drop_tag();
      end else if (tag_len_q >= 3) begin
        tag_ovf_q = 1'b1;
      end else begin
        tag_body_q[tag_len_q] = b;
        tag_len_q++;
      end
    end else if (b == OPEN_CH) begin
      drop_tag();
      tag_open_q = 1'b1;
    end else begin
      res[0] = b;
      n = 1;
    end
    if (eop)
      drop_tag();
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one byte, waits for the transaction, records what it causes.
  // tvalid is left high on return so back-to-back bytes need no extra edge.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eop,
                           input int typed_n = PRED, input logic [39:0] typed = '0);
    int         gap;
    int         n;
    int         j;
    logic [7:0] res [5];
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct)
      gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eop;
    @(posedge clk_i);
    while (!s_axis_tready)
      @(posedge clk_i);
    codec_convert(b, eop, res, n);
    if (typed_n >= 0) begin
      n = typed_n;
      for (j = 0; j < n; j++)
        res[j] = typed[8 * (n - 1 - j) +: 8];
    end
    for (j = 0; j < n; j++)
      pending_bytes.push_back('{data: res[j], last: (j == n - 1)});
  endtask

  // stop offering, let every result drain, then give the block time to go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of the mode register, then a read-back of it
  task automatic write_mode(input logic m);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready)
      @(posedge clk_i);
    mode_q = m;
    // straight into the setup phase of the read
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready)
      @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {31'd0, m})
      note_mismatch("mode read-back", {31'd0, m}, rd);
  endtask

  task automatic send_expand_burst(input int quota);
    int         i;
    int         pick;
    logic [7:0] b;
    for (i = 0; i < quota; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        b = 8'($urandom_range(32));
      else if (pick < 55)
        b = DEL_CODE;
      else
        b = 8'($urandom);
      send_byte(b, ($urandom_range(7) == 0));
    end
  endtask

  // mostly well-formed tags with random names, some damaged, some plain noise
  task automatic send_collapse_burst(input int quota);
    int         sent;
    int         pick;
    int         len;
    int         ending;
    int         j;
    string      nm;
    logic [7:0] ch;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      nm   = mnemonic_names[$urandom_range(NAME_COUNT - 1)];
      if (pick < 55) begin
        send_byte(OPEN_CH, 1'b0);
        for (j = 0; j < nm.len(); j++)
          send_byte(8'(nm.getc(j)), 1'b0);
        send_byte(CLOSE_CH, ($urandom_range(7) == 0));
        sent += nm.len() + 2;
      end else if (pick < 75) begin
        // damaged: wrong length, case flipped, random chars, or left open
        len    = $urandom_range(5);
        ending = $urandom_range(2);
        send_byte(OPEN_CH, 1'b0);
        for (j = 0; j < len; j++) begin
          if (j < nm.len() && $urandom_range(3) != 0)
            ch = 8'(nm.getc(j)) ^ (($urandom_range(3) == 0) ? 8'h20 : 8'h00);
          else
            ch = 8'($urandom);
          send_byte(ch, (ending == 1 && j == len - 1));
        end
        if (ending == 0)
          send_byte(CLOSE_CH, 1'b0);
        sent += len + 2;
      end else begin
        send_byte(8'($urandom), ($urandom_range(9) == 0));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each result transaction and drives tready.
  // A long hold-off is counted here once the main thread asks for it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    codec_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_bytes.size() == 0) begin
          note_mismatch("unexpected result", 32'd0, {23'd0, m_axis_tlast, m_axis_tdata});
        end else begin
          want = pending_bytes.pop_front();
          if (m_axis_tdata !== want.data)
            note_mismatch("out_byte", 32'(want.data), 32'(m_axis_tdata));
          if (m_axis_tlast !== want.last)
            note_mismatch("last_of_run", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      if (long_stall_req && !stall_taken) begin
        stall_taken   <= 1'b1;
        stall_left    <= LONG_STALL;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on either stream or the APB port resets it
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    int seg;
    int r;
    logic m;

    mode_q = MODE_EXPAND;
    drop_tag();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; a mode change waits for the block to go idle first
    write_mode(MODE_EXPAND);
    for (r = 0; r < $size(DIR_ROWS); r++) begin
      if (DIR_ROWS[r].mode != mode_q) begin
        settle();
        write_mode(DIR_ROWS[r].mode);
      end
      send_byte(DIR_ROWS[r].in_b, DIR_ROWS[r].eop, DIR_ROWS[r].n_res, DIR_ROWS[r].res);
    end
    // tag was dropped by end of packet, so this is plain text
    send_byte("U", 1'b0, 1, "U");

    // random phases: slow receiver, then slow sender, then no idling
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 7;
          rx_idle_pct <= 88;
        end
        1: begin
          tx_idle_pct  = 88;
          rx_idle_pct <= 7;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        m = 1'((seg + ph) % 2);
        settle();
        write_mode(m);
        // receiver holds off while expand traffic keeps coming: the block fills
        if (ph == 2 && seg == 0)
          long_stall_req <= 1'b1;
        if (m == MODE_EXPAND)
          send_expand_burst(BURST_ITEMS);
        else
          send_collapse_burst(BURST_ITEMS);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* control_char_mnemonic_codec_top.f */
rtl/ccmc_pkg.sv
rtl/control_char_mnemonic_codec_top.sv
verif/tb_control_char_mnemonic_codec_top.sv
